// ===== hw/rtl/swdf_pkg.sv =====
// Shared constants, register codes and interface types for the scale weight display filter.
package swdf_pkg;

  localparam int AdcW     = 24;
  localparam int NetW     = AdcW + 1;
  localparam int CalW     = 26;
  localparam int ThrW     = 16;
  localparam int AlphaW   = 9;
  localparam int WgtW     = 33;
  localparam int ShownW   = 26;
  localparam int DiffW    = WgtW + 1;
  localparam int MulW     = DiffW + CalW;
  localparam int EwW      = 45;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = CalW;

  // Q24 product to Q8 grams, EWMA in 1/256, display Q8 to half grams
  localparam int WShift     = 16;
  localparam int EwShift    = 8;
  localparam int ShownShift = 7;

  localparam logic signed [CalW-1:0] CalReset      = -26'sd1124073;
  localparam logic [ThrW-1:0]        ZeroSnapReset = 16'd512;
  localparam logic [ThrW-1:0]        RemHighReset  = 16'd5120;
  localparam logic [ThrW-1:0]        RemLowReset   = 16'd2560;
  localparam logic [AlphaW-1:0]      AlphaReset    = 9'd77;
  localparam logic [AlphaW-1:0]      AlphaMax      = 9'd256;

  typedef enum logic [CfgIdxW-1:0] {
    RegCal     = 3'd0,
    RegZeroSnap = 3'd1,
    RegRemHigh = 3'd2,
    RegRemLow  = 3'd3,
    RegAlpha   = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic signed [CalW-1:0] cal;
    logic [ThrW-1:0]        zero_snap;
    logic [ThrW-1:0]        rem_high;
    logic [ThrW-1:0]        rem_low;
    logic [AlphaW-1:0]      alpha;
  } cfg_t;

  typedef struct packed {
    logic accept;   // capture request, multiply net by factor
    logic ld_w;     // round and saturate weight
    logic mul_ew;   // multiply alpha by (weight - display)
    logic upd;      // update filter state or take tare
    logic ld_out;   // load output register
  } dp_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_sts_t;

endpackage

// ===== hw/rtl/swdf_cfg.sv =====
// Configuration register file for the scale weight display filter.
module swdf_cfg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [swdf_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [swdf_pkg::CfgDataW-1:0]      cfg_wdata_i,
  output swdf_pkg::cfg_t                     cfg_o
);

  swdf_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal       <= swdf_pkg::CalReset;
      cfg_q.zero_snap <= swdf_pkg::ZeroSnapReset;
      cfg_q.rem_high  <= swdf_pkg::RemHighReset;
      cfg_q.rem_low   <= swdf_pkg::RemLowReset;
      cfg_q.alpha     <= swdf_pkg::AlphaReset;
    end else if (cfg_we_i) begin
      unique case (swdf_pkg::cfg_reg_e'(cfg_idx_i))
        swdf_pkg::RegCal:      cfg_q.cal       <= cfg_wdata_i[swdf_pkg::CalW-1:0];
        swdf_pkg::RegZeroSnap: cfg_q.zero_snap <= cfg_wdata_i[swdf_pkg::ThrW-1:0];
        swdf_pkg::RegRemHigh:  cfg_q.rem_high  <= cfg_wdata_i[swdf_pkg::ThrW-1:0];
        swdf_pkg::RegRemLow:   cfg_q.rem_low   <= cfg_wdata_i[swdf_pkg::ThrW-1:0];
        swdf_pkg::RegAlpha:    cfg_q.alpha     <= cfg_wdata_i[swdf_pkg::AlphaW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== hw/rtl/swdf_ctrl.sv =====
// Sequencing state machine for the scale weight display filter.
module swdf_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              op_i,
  output logic              in_stall_o,
  input  swdf_pkg::dp_sts_t sts_i,
  output swdf_pkg::dp_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    StIdle,
    StWgt,
    StMulEw,
    StUpd,
    StOut
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = op_i ? StUpd : StWgt;
        end
      end
      StWgt: begin
        cmd_o.ld_w = 1'b1;
        state_d    = StMulEw;
      end
      StMulEw: begin
        cmd_o.mul_ew = 1'b1;
        state_d      = StUpd;
      end
      StUpd: begin
        cmd_o.upd = 1'b1;
        state_d   = StOut;
      end
      StOut: begin
        if (!sts_i.out_busy) begin
          cmd_o.ld_out = 1'b1;
          state_d      = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != StIdle);

endmodule

// ===== hw/rtl/swdf_dp.sv =====
// Datapath: tare offset, shared multiplier, weight rounding, EWMA filter and output register.
module swdf_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  swdf_pkg::cfg_t                      cfg_i,
  input  swdf_pkg::dp_cmd_t                   cmd_i,
  output swdf_pkg::dp_sts_t                   sts_o,
  input  logic                                op_i,
  input  logic signed [swdf_pkg::AdcW-1:0]    raw_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swdf_pkg::NetW-1:0]    net_count_o,
  output logic signed [swdf_pkg::WgtW-1:0]    weight_q8_o,
  output logic signed [swdf_pkg::ShownW-1:0]  shown_half_grams_o,
  output logic                                tare_done_o
);

  localparam int MulW   = swdf_pkg::MulW;
  localparam int WgtW   = swdf_pkg::WgtW;
  localparam int EwW    = swdf_pkg::EwW;
  localparam int ShW    = WgtW + 1;
  localparam int ShownW = swdf_pkg::ShownW;

  // filter state
  logic signed [swdf_pkg::AdcW-1:0] offset_q;
  logic signed [WgtW-1:0]           disp_q, disp_d;
  logic signed [WgtW-1:0]           prev_q;

  // per-request payload
  logic                             op_q;
  logic signed [swdf_pkg::AdcW-1:0] raw_q;
  logic signed [swdf_pkg::NetW-1:0] net_q;
  logic signed [MulW-1:0]           prod_q;
  logic signed [WgtW-1:0]           w_q, w_d;

  logic                             out_valid_q;
  logic signed [swdf_pkg::NetW-1:0] net_out_q;
  logic signed [WgtW-1:0]           wgt_out_q;
  logic signed [ShownW-1:0]         shown_out_q, shown_d;
  logic                             tare_out_q;

  // shared multiplier
  logic signed [swdf_pkg::NetW-1:0]  net_in;
  logic signed [swdf_pkg::DiffW-1:0] diff;
  logic [swdf_pkg::AlphaW-1:0]       alpha_sat;
  logic signed [swdf_pkg::DiffW-1:0] mul_a;
  logic signed [swdf_pkg::CalW-1:0]  mul_b;
  logic signed [MulW-1:0]            mul_p;

  assign net_in    = swdf_pkg::NetW'(raw_count_i) - swdf_pkg::NetW'(offset_q);
  assign diff      = swdf_pkg::DiffW'(w_q) - swdf_pkg::DiffW'(disp_q);
  assign alpha_sat = (cfg_i.alpha > swdf_pkg::AlphaMax) ? swdf_pkg::AlphaMax : cfg_i.alpha;
  assign mul_a     = cmd_i.mul_ew ? diff : swdf_pkg::DiffW'(net_in);
  assign mul_b     = cmd_i.mul_ew ? $signed(swdf_pkg::CalW'(alpha_sat)) : cfg_i.cal;
  assign mul_p     = mul_a * mul_b;

  // weight: round half away from zero, shift to Q8, saturate
  logic signed [MulW-1:0] w_sum, w_sh;
  assign w_sum = prod_q + MulW'(1 << (swdf_pkg::WShift - 1)) - MulW'(prod_q[MulW-1]);
  assign w_sh  = w_sum >>> swdf_pkg::WShift;
  always_comb begin
    if ((&w_sh[MulW-1:WgtW-1]) || !(|w_sh[MulW-1:WgtW-1])) begin
      w_d = w_sh[WgtW-1:0];
    end else begin
      w_d = w_sh[MulW-1] ? {1'b1, {(WgtW-1){1'b0}}} : {1'b0, {(WgtW-1){1'b1}}};
    end
  end

  // display update: disp + alpha*(w - disp)/256, or zero on a zero snap or a removal
  logic [WgtW-1:0]       abs_w, abs_prev;
  logic                  snap, removed;
  logic signed [EwW-1:0] ew_sum, ew_rnd, ew_sh;

  assign abs_w    = w_q[WgtW-1] ? (~w_q + 1'b1) : w_q;
  assign abs_prev = prev_q[WgtW-1] ? (~prev_q + 1'b1) : prev_q;
  assign snap     = abs_w < WgtW'(cfg_i.zero_snap);
  assign removed  = (abs_prev > WgtW'(cfg_i.rem_high)) && (abs_w < WgtW'(cfg_i.rem_low));

  assign ew_sum = (EwW'(disp_q) <<< swdf_pkg::EwShift) + $signed(prod_q[EwW-1:0]);
  assign ew_rnd = ew_sum + EwW'(1 << (swdf_pkg::EwShift - 1)) - EwW'(ew_sum[EwW-1]);
  assign ew_sh  = ew_rnd >>> swdf_pkg::EwShift;

  always_comb begin
    if (snap || removed) begin
      disp_d = '0;
    end else if ((&ew_sh[EwW-1:WgtW-1]) || !(|ew_sh[EwW-1:WgtW-1])) begin
      disp_d = ew_sh[WgtW-1:0];
    end else begin
      disp_d = ew_sh[EwW-1] ? {1'b1, {(WgtW-1){1'b0}}} : {1'b0, {(WgtW-1){1'b1}}};
    end
  end

  // display in half grams
  logic signed [ShW-1:0] sh_sum, sh_sh;
  assign sh_sum = ShW'(disp_q) + ShW'(1 << (swdf_pkg::ShownShift - 1)) - ShW'(disp_q[WgtW-1]);
  assign sh_sh  = sh_sum >>> swdf_pkg::ShownShift;
  always_comb begin
    if ((&sh_sh[ShW-1:ShownW-1]) || !(|sh_sh[ShW-1:ShownW-1])) begin
      shown_d = sh_sh[ShownW-1:0];
    end else begin
      shown_d = sh_sh[ShW-1] ? {1'b1, {(ShownW-1){1'b0}}} : {1'b0, {(ShownW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q    <= '0;
      disp_q      <= '0;
      prev_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.upd) begin
        if (op_q) begin
          offset_q <= raw_q;
          disp_q   <= '0;
          prev_q   <= '0;
        end else begin
          disp_q <= disp_d;
          prev_q <= w_q;
        end
      end
      if (cmd_i.ld_out) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q  <= op_i;
      raw_q <= raw_count_i;
      net_q <= net_in;
    end
    if (cmd_i.accept || cmd_i.mul_ew) begin
      prod_q <= mul_p;
    end
    if (cmd_i.ld_w) begin
      w_q <= w_d;
    end
    if (cmd_i.ld_out) begin
      net_out_q   <= op_q ? '0 : net_q;
      wgt_out_q   <= op_q ? '0 : w_q;
      shown_out_q <= op_q ? '0 : shown_d;
      tare_out_q  <= op_q;
    end
  end

  assign sts_o.out_busy     = out_valid_q && out_stall_i;
  assign out_valid_o        = out_valid_q;
  assign net_count_o        = net_out_q;
  assign weight_q8_o        = wgt_out_q;
  assign shown_half_grams_o = shown_out_q;
  assign tare_done_o        = tare_out_q;

endmodule

// ===== hw/rtl/scale_weight_display_filter_unit.sv =====
// Top level of the load-cell tare, scale and display filter.
//
// Input channel (in_valid_i / in_stall_o) carries one request: op_i selects a
// weigh sample (0) or a tare capture (1), raw_count_i is the averaged signed ADC
// count. A request is taken when in_valid_i is high and in_stall_o is low.
// Output channel (out_valid_o / out_stall_i) returns one result per request:
// net count, unfiltered weight (grams Q8), display weight in 0.5 g steps and
// the tare flag. The result sits in an output register until taken.
// A weigh request runs StWgt, StMulEw, StUpd and StOut before the next acceptance;
// one 34x26 multiplier is shared by the net*factor and the alpha*(weight-display)
// products, each followed by a rounding step. A tare request runs StUpd and StOut.
// out_valid_o rises once StOut has loaded the output register. If the receiver
// stalls while a result is still held, the block finishes the next request and
// waits with in_stall_o high until the output register frees up.
// Reset loads the register defaults, clears the zero offset, the display and the
// previous weight, and empties the output register.
// Configuration: cfg_we_i writes cfg_wdata_i to register cfg_idx_i (0 cal_factor,
// 1 zero_snap, 2 removal_high, 3 removal_low, 4 alpha); write only when idle.
module scale_weight_display_filter_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [swdf_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  logic [swdf_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                op_i,
  input  logic signed [swdf_pkg::AdcW-1:0]    raw_count_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [swdf_pkg::NetW-1:0]    net_count_o,
  output logic signed [swdf_pkg::WgtW-1:0]    weight_q8_o,
  output logic signed [swdf_pkg::ShownW-1:0]  shown_half_grams_o,
  output logic                                tare_done_o
);

  swdf_pkg::cfg_t    cfg;
  swdf_pkg::dp_cmd_t cmd;
  swdf_pkg::dp_sts_t sts;

  swdf_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  swdf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .op_i       (op_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  swdf_dp u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cfg_i              (cfg),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .op_i               (op_i),
    .raw_count_i        (raw_count_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .net_count_o        (net_count_o),
    .weight_q8_o        (weight_q8_o),
    .shown_half_grams_o (shown_half_grams_o),
    .tare_done_o        (tare_done_o)
  );

endmodule

// ===== hw/rtl/swdf_chk.sv =====
// Port-level checker for the scale weight display filter, bound to the top level.
module swdf_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_stall_o,
  input logic                                out_valid_o,
  input logic                                out_stall_i,
  input logic signed [swdf_pkg::NetW-1:0]    net_count_o,
  input logic signed [swdf_pkg::WgtW-1:0]    weight_q8_o,
  input logic signed [swdf_pkg::ShownW-1:0]  shown_half_grams_o,
  input logic                                tare_done_o
);

  // a tare result carries an all-zero payload
  a_tare_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && tare_done_o) |->
      (net_count_o == '0 && weight_q8_o == '0 && shown_half_grams_o == '0))
    else $error("tare result with nonzero payload");

  // one request at a time: busy right after acceptance
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("request accepted while previous one in flight");

  // a new result only appears while a request is being worked on
  a_result_from_request: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a request in flight");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(net_count_o) && $stable(weight_q8_o) &&
       $stable(shown_half_grams_o) && $stable(tare_done_o)))
    else $error("stalled result changed");

endmodule

bind scale_weight_display_filter_unit swdf_chk u_swdf_chk (.*);
